// ===== hdl/cleb_pkg.sv =====
// Shared constants and control types for the console line edit buffer.
package cleb_pkg;

  localparam int LINE_LEN  = 128;
  localparam int TAB_WIDTH = 8;

  localparam int ADDR_W = $clog2(LINE_LEN);
  localparam int CNT_W  = $clog2(LINE_LEN + 1);

  localparam logic [CNT_W-1:0] LEN_C = CNT_W'(LINE_LEN);
  localparam logic [CNT_W-1:0] TAB_C = CNT_W'(TAB_WIDTH);

  localparam logic [7:0] KEY_ESC   = 8'h1b;
  localparam logic [7:0] KEY_TAB   = 8'h09;
  localparam logic [7:0] KEY_BS    = 8'h08;
  localparam logic [7:0] KEY_LF    = 8'h0a;
  localparam logic [7:0] KEY_CR    = 8'h0d;
  localparam logic [7:0] KEY_SPACE = 8'h20;

  // controller -> datapath
  typedef struct packed {
    logic load;   // latch item, launch store read
    logic look;   // evaluate item with read data
    logic fill;   // write one tab space
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic tab_start;
    logic fill_last;
  } status_t;

endpackage

// ===== hdl/console_line_edit_buffer_unit.sv =====
// Console line edit buffer: each item is latched, then evaluated with the store read data.
// One item at a time; busy is high from the cycle after accept and is low again
// in the result cycle. A tab writes one space per cycle through the single store write port.
// The result strobe done_o lasts one cycle; a new item may start in that cycle.
// Reset (rst_ni low, asynchronous) clears the line state and store valid bits;
// the line store reads as zeros until written.
module console_line_edit_buffer_unit import cleb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic       mode_i,
  input  logic [7:0] key_byte_i,
  output logic       done_o,
  output logic       echo_valid_o,
  output logic [7:0] echo_char_o,
  output logic       read_valid_o,
  output logic [7:0] read_char_o,
  output logic       line_ready_o,
  output logic       key_dropped_o
);

  cmd_t    cmd;
  status_t status;

  cleb_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  cleb_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .mode_i        (mode_i),
    .key_byte_i    (key_byte_i),
    .status_o      (status),
    .done_o        (done_o),
    .echo_valid_o  (echo_valid_o),
    .echo_char_o   (echo_char_o),
    .read_valid_o  (read_valid_o),
    .read_char_o   (read_char_o),
    .line_ready_o  (line_ready_o),
    .key_dropped_o (key_dropped_o)
  );

endmodule

// ===== hdl/cleb_ctrl.sv =====
// Sequencing state machine of the console line edit buffer.
module cleb_ctrl import cleb_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  status_t status_i,
  output cmd_t    cmd_o,
  output logic    busy_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOK,
    ST_FILL
  } state_e;

  state_e state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (start_i) state_q <= ST_LOOK;
        end
        ST_LOOK: begin
          state_q <= status_i.tab_start ? ST_FILL : ST_IDLE;
        end
        ST_FILL: begin
          if (status_i.fill_last) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy_o     = (state_q != ST_IDLE);
  assign cmd_o.load = start_i && (state_q == ST_IDLE);
  assign cmd_o.look = (state_q == ST_LOOK);
  assign cmd_o.fill = (state_q == ST_FILL);

endmodule

// ===== hdl/cleb_dp.sv =====
// Datapath: line store, counters and result registers.
module cleb_dp import cleb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cmd_t       cmd_i,
  input  logic       mode_i,
  input  logic [7:0] key_byte_i,
  output status_t    status_o,
  output logic       done_o,
  output logic       echo_valid_o,
  output logic [7:0] echo_char_o,
  output logic       read_valid_o,
  output logic [7:0] read_char_o,
  output logic       line_ready_o,
  output logic       key_dropped_o
);

  logic [7:0]        line_store_q [LINE_LEN];
  logic [LINE_LEN-1:0] vld_q;
  logic [7:0]        rd_data_q;
  logic              rd_vld_q;

  logic              mode_q;
  logic [7:0]        key_q;

  logic [CNT_W-1:0]  fill_q, fill_d;
  logic [CNT_W-1:0]  rpos_q, rpos_d;
  logic              cmpl_q, cmpl_d;
  logic              done_q, done_d;

  logic              echo_valid_q, echo_valid_d;
  logic [7:0]        echo_char_q, echo_char_d;
  logic              read_valid_q, read_valid_d;
  logic [7:0]        read_char_q, read_char_d;
  logic              drop_q, drop_d;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [7:0]        wdata;
  logic [ADDR_W-1:0] raddr;

  logic [7:0]        rd_byte;
  logic [7:0]        key_eff;
  logic [CNT_W-1:0]  fill_inc;
  logic [CNT_W-1:0]  fill_after;
  logic [CNT_W-1:0]  rpos_inc;

  assign raddr   = mode_i ? rpos_q[ADDR_W-1:0] : fill_q[ADDR_W-1:0];
  // unwritten entries read as zero
  assign rd_byte = rd_vld_q ? rd_data_q : 8'h00;

  always_ff @(posedge clk_i) begin
    if (we) line_store_q[waddr] <= wdata;
    if (cmd_i.load) rd_data_q <= line_store_q[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (we) vld_q[waddr] <= 1'b1;
      if (cmd_i.load) rd_vld_q <= vld_q[raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q <= mode_i;
      key_q  <= key_byte_i;
    end
    echo_valid_q <= echo_valid_d;
    echo_char_q  <= echo_char_d;
    read_valid_q <= read_valid_d;
    read_char_q  <= read_char_d;
    drop_q       <= drop_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      rpos_q <= '0;
      cmpl_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      rpos_q <= rpos_d;
      cmpl_q <= cmpl_d;
      done_q <= done_d;
    end
  end

  always_comb begin
    fill_d       = fill_q;
    rpos_d       = rpos_q;
    cmpl_d       = cmpl_q;
    done_d       = 1'b0;
    echo_valid_d = echo_valid_q;
    echo_char_d  = echo_char_q;
    read_valid_d = read_valid_q;
    read_char_d  = read_char_q;
    drop_d       = drop_q;
    we           = 1'b0;
    waddr        = fill_q[ADDR_W-1:0];
    wdata        = KEY_SPACE;
    status_o     = '0;

    fill_inc   = fill_q + 1'b1;
    rpos_inc   = rpos_q + 1'b1;
    fill_after = (fill_q < LEN_C) ? fill_inc : fill_q;

    // ESC recalls the byte left at the current position by the previous line
    if (key_q == KEY_ESC) begin
      key_eff = (fill_q < LEN_C) ? rd_byte : 8'h00;
    end else begin
      key_eff = key_q;
    end

    if (cmd_i.look) begin
      echo_valid_d = 1'b0;
      echo_char_d  = 8'h00;
      read_valid_d = 1'b0;
      read_char_d  = 8'h00;
      drop_d       = 1'b0;
      if (!mode_q) begin
        if (cmpl_q) begin
          drop_d = 1'b1;
          done_d = 1'b1;
        end else begin
          echo_valid_d = 1'b1;
          echo_char_d  = key_eff;
          if (key_eff == KEY_TAB) begin
            status_o.tab_start = 1'b1;
          end else if (key_eff == KEY_BS) begin
            if (fill_q != '0) fill_d = fill_q - 1'b1;
            done_d = 1'b1;
          end else begin
            if (fill_q < LEN_C) begin
              we     = 1'b1;
              wdata  = key_eff;
              fill_d = fill_inc;
            end
            if (key_eff == KEY_LF || key_eff == KEY_CR || fill_after >= LEN_C) begin
              cmpl_d = 1'b1;
            end
            done_d = 1'b1;
          end
        end
      end else begin
        if (cmpl_q) begin
          read_valid_d = 1'b1;
          read_char_d  = rd_byte;
          if (rd_byte == KEY_LF || rd_byte == KEY_CR || rpos_inc >= fill_q) begin
            rpos_d = '0;
            fill_d = '0;
            cmpl_d = 1'b0;
          end else begin
            rpos_d = rpos_inc;
          end
        end
        done_d = 1'b1;
      end
    end else if (cmd_i.fill) begin
      if (fill_q < LEN_C) begin
        we     = 1'b1;
        fill_d = fill_inc;
      end
      // stop at the next tab stop or a full store
      if ((fill_after % TAB_C) == '0 || fill_after >= LEN_C) begin
        status_o.fill_last = 1'b1;
        done_d             = 1'b1;
        if (fill_after >= LEN_C) cmpl_d = 1'b1;
      end
    end
  end

  assign done_o        = done_q;
  assign echo_valid_o  = echo_valid_q;
  assign echo_char_o   = echo_char_q;
  assign read_valid_o  = read_valid_q;
  assign read_char_o   = read_char_q;
  assign line_ready_o  = cmpl_q;
  assign key_dropped_o = drop_q;

endmodule

// ===== hdl/cleb_chk.sv =====
// Port-level checks for the console line edit buffer, bound to the top level.
module cleb_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o,
  input logic echo_valid_o,
  input logic read_valid_o,
  input logic line_ready_o,
  input logic key_dropped_o
);

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after a transfer in");

  a_done_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe held for two cycles");

  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && echo_valid_o) |-> (!read_valid_o && !key_dropped_o))
    else $error("echo together with read or drop");

  a_drop_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && key_dropped_o) |-> line_ready_o)
    else $error("key dropped without a completed line");

endmodule

bind console_line_edit_buffer_unit cleb_chk u_cleb_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .done_o        (done_o),
  .echo_valid_o  (echo_valid_o),
  .read_valid_o  (read_valid_o),
  .line_ready_o  (line_ready_o),
  .key_dropped_o (key_dropped_o)
);

// ===== sim/tb_console_line_edit_buffer_unit.sv =====
// Testbench for console_line_edit_buffer_unit: directed and random keys/reads against a mirror.
`timescale 1ns / 100ps

module tb_console_line_edit_buffer_unit;
  import cleb_pkg::*;

  localparam int ITEM_TARGET    = 950;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 12;
  localparam int QUIET_FROM     = 400;
  localparam int QUIET_TO       = 600;

  typedef struct packed {
    logic       echo_valid;
    logic [7:0] echo_char;
    logic       read_valid;
    logic [7:0] read_char;
    logic       line_ready;
    logic       key_dropped;
  } line_result_t;

  // Mirror of the line buffer plus the outputs still owed by the block.
  class line_edit_mirror;
    logic [7:0]   store [LINE_LEN];
    int unsigned  fill;
    int unsigned  rpos;
    bit           line_done;
    line_result_t owed_outputs[$];
    int           errors;
    int           checked;

    function void clear();
      foreach (store[i]) store[i] = 8'h00;
      fill = 0;
      rpos = 0;
      line_done = 1'b0;
    endfunction

    function void put_byte(logic [7:0] b);
      if (fill < LINE_LEN) begin
        store[fill] = b;
        fill++;
      end
    endfunction

    // Applies one transfer to the mirror; returns 1 when it was not ignored.
    function bit log_input(logic mode, logic [7:0] key_in);
      line_result_t r;
      logic [7:0]   key;
      logic [7:0]   c;
      bit           active;
      r = '0;
      key = key_in;
      active = 1'b1;
      if (!mode) begin
        if (line_done) begin
          r.key_dropped = 1'b1;
          active = 1'b0;
        end else begin
          // escape recalls what the previous line left at this position
          if (key == KEY_ESC) key = (fill < LINE_LEN) ? store[fill] : 8'h00;
          r.echo_valid = 1'b1;
          r.echo_char = key;
          if (key == KEY_TAB) begin
            do put_byte(KEY_SPACE);
            while ((fill % TAB_WIDTH) != 0 && fill < LINE_LEN);
            if (fill >= LINE_LEN) line_done = 1'b1;
          end else if (key == KEY_BS) begin
            if (fill > 0) fill--;
          end else begin
            put_byte(key);
            if (key == KEY_LF || key == KEY_CR || fill >= LINE_LEN) line_done = 1'b1;
          end
        end
      end else if (line_done) begin
        c = (rpos < LINE_LEN) ? store[rpos] : 8'h00;
        r.read_valid = 1'b1;
        r.read_char = c;
        rpos++;
        if (c == KEY_LF || c == KEY_CR || rpos >= fill) begin
          rpos = 0;
          fill = 0;
          line_done = 1'b0;
        end
      end else begin
        active = 1'b0;
      end
      r.line_ready = line_done;
      owed_outputs.push_back(r);
      return active;
    endfunction

    task report(string msg);
      errors++;
      $display("%s", msg);
    endtask

    task check_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
        report($sformatf("result %0d: %s is %h, expected %h", checked, name, got, want));
    endtask

    task check_output(line_result_t got);
      line_result_t want;
      if (owed_outputs.size() == 0) begin
        report($sformatf("result %0d: strobe with no item outstanding", checked));
      end else begin
        want = owed_outputs.pop_front();
        check_field("echo_valid", 8'(got.echo_valid), 8'(want.echo_valid));
        check_field("echo_char", got.echo_char, want.echo_char);
        check_field("read_valid", 8'(got.read_valid), 8'(want.read_valid));
        check_field("read_char", got.read_char, want.read_char);
        check_field("line_ready", 8'(got.line_ready), 8'(want.line_ready));
        check_field("key_dropped", 8'(got.key_dropped), 8'(want.key_dropped));
      end
      checked++;
    endtask
  endclass

  logic       clk_i      = 1'b0;
  logic       rst_ni     = 1'b0;
  logic       start      = 1'b0;
  logic       mode_i     = 1'b0;
  logic [7:0] key_byte_i = 8'h00;
  logic       busy;
  logic       done_o;
  logic       echo_valid_o;
  logic [7:0] echo_char_o;
  logic       read_valid_o;
  logic [7:0] read_char_o;
  logic       line_ready_o;
  logic       key_dropped_o;

  line_edit_mirror mirror;
  int              idle_pct = 35;
  int              active_items = 0;
  int              stalled_cycles = 0;

  console_line_edit_buffer_unit u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .mode_i       (mode_i),
    .key_byte_i   (key_byte_i),
    .done_o       (done_o),
    .echo_valid_o (echo_valid_o),
    .echo_char_o  (echo_char_o),
    .read_valid_o (read_valid_o),
    .read_char_o  (read_char_o),
    .line_ready_o (line_ready_o),
    .key_dropped_o(key_dropped_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Random idle cycles, then hold the item until the block takes it.
  task automatic send_item(input logic m, input logic [7:0] k);
    while ($urandom_range(99) < idle_pct) begin
      start      <= 1'b0;
      mode_i     <= 1'($urandom);
      key_byte_i <= 8'($urandom);
      @(posedge clk_i);
    end
    start      <= 1'b1;
    mode_i     <= m;
    key_byte_i <= k;
    do @(posedge clk_i); while (busy);
    if (mirror.log_input(m, k)) active_items++;
  endtask

  function automatic logic [7:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 55) return 8'($urandom_range(32, 126));
    if (r < 65) return KEY_TAB;
    if (r < 76) return KEY_BS;
    if (r < 88) return KEY_ESC;
    return 8'($urandom);
  endfunction

  always @(posedge clk_i) begin : result_monitor
    line_result_t got;
    if (rst_ni && done_o) begin
      got.echo_valid  = echo_valid_o;
      got.echo_char   = echo_char_o;
      got.read_valid  = read_valid_o;
      got.read_char   = read_char_o;
      got.line_ready  = line_ready_o;
      got.key_dropped = key_dropped_o;
      mirror.check_output(got);
    end
  end

  // Ends the run when neither side makes progress for too long.
  always @(posedge clk_i) begin
    if ((start && !busy) || done_o) begin
      stalled_cycles <= 0;
    end else if (stalled_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_console_line_edit_buffer_unit NOT OK");
      $finish;
    end else begin
      stalled_cycles <= stalled_cycles + 1;
    end
  end

  initial begin
    int  n_keys;
    bit  long_line;
    mirror = new;
    mirror.clear();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty read, edits at fill zero, recall of reset contents, tab, LF
    send_item(1'b1, 8'h00);
    send_item(1'b0, KEY_BS);
    send_item(1'b0, KEY_ESC);
    send_item(1'b0, KEY_BS);
    send_item(1'b0, 8'hff);
    send_item(1'b0, KEY_TAB);
    send_item(1'b0, KEY_BS);
    send_item(1'b0, KEY_LF);
    send_item(1'b0, 8'h71);          // dropped during readout
    while (mirror.line_done) send_item(1'b1, 8'hff);
    // recall of the previous line's first byte, then CR
    send_item(1'b0, KEY_ESC);
    send_item(1'b0, 8'h00);
    send_item(1'b0, KEY_CR);
    while (mirror.line_done) send_item(1'b1, 8'h00);
    send_item(1'b1, 8'h55);

    // random lines: mostly short, a few long enough to fill the store
    while (active_items < ITEM_TARGET) begin
      idle_pct  = (active_items >= QUIET_FROM && active_items < QUIET_TO) ? 0 : 35;
      long_line = ($urandom_range(99) < 5);
      n_keys    = long_line ? $urandom_range(118, 135) : $urandom_range(0, 20);
      for (int i = 0; i < n_keys && !mirror.line_done; i++) begin
        if ($urandom_range(99) < 4) send_item(1'b1, 8'($urandom));
        send_item(1'b0, pick_key());
      end
      if (!mirror.line_done && $urandom_range(99) < 85)
        send_item(1'b0, $urandom_range(1) ? KEY_CR : KEY_LF);
      while (mirror.line_done) begin
        if ($urandom_range(99) < 10) send_item(1'b0, 8'($urandom));
        else send_item(1'b1, 8'($urandom));
      end
    end
    start <= 1'b0;

    while (mirror.owed_outputs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mirror.errors == 0 && mirror.owed_outputs.size() == 0) begin
      $display("tb_console_line_edit_buffer_unit OK");
    end else begin
      $display("tb_console_line_edit_buffer_unit NOT OK");
    end
    $finish;
  end

endmodule
